// ===== rtl/tdeq_pkg.sv =====
// Shared types and constants for the tail-drop egress queue.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package tdeq_pkg;

  // Buffer geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int SIZE_W   = 16;
  localparam int TICK_W   = 32;
  localparam int STAT_W   = 32;
  localparam int SUM_W    = 48;
  localparam int OCC_W    = 7;
  localparam int CAP_W    = 7;
  localparam int BPT_W    = 20;
  localparam int STS_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 20;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(64);
  localparam logic [BPT_W-1:0] BPT_RST = BPT_W'(5400);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_TICK = 1'b1;

  // Item opcodes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Result status codes
  localparam logic [STS_W-1:0] STS_ACCEPTED = 3'd0;
  localparam logic [STS_W-1:0] STS_DROPPED  = 3'd1;
  localparam logic [STS_W-1:0] STS_IDLE     = 3'd2;
  localparam logic [STS_W-1:0] STS_SENDING  = 3'd3;
  localparam logic [STS_W-1:0] STS_DEPARTED = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input beat
    logic read;   // read the head entry
    logic exec;   // apply the item and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new beat this cycle
  } dp_sts_t;

endpackage

// ===== rtl/tdeq_ctrl.sv =====
// Sequencer for the tail-drop egress queue: accept, head read, execute.
// Depends on tdeq_pkg for the command and status structs.
`timescale 1ns / 1ps

module tdeq_ctrl import tdeq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd      = '0;
    cmd.load = (state == ST_IDLE) && item_valid && !item_stall;
    cmd.read = (state == ST_READ);
    cmd.exec = (state == ST_EXEC) && sts.out_free;
  end

  // State and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_stall <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state      <= ST_READ;
            item_stall <= 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (sts.out_free) begin
            state      <= ST_IDLE;
            item_stall <= 1'b0;
          end
        end
        default: begin
          state      <= ST_IDLE;
          item_stall <= 1'b0;
        end
      endcase
    end
  end

  // Stall is released exactly when the sequencer is back in idle
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    (item_stall == 1'b0) == (state == ST_IDLE))
    else $error("item_stall out of step with sequencer state");

  // An item never enters execute without first passing through the head read
  a_exec_after_read: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EXEC) |-> $past(cmd.read))
    else $error("execute entered without a head read");

  // A captured beat always proceeds to the head read
  a_load_to_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_READ))
    else $error("captured beat did not start a head read");

endmodule

// ===== rtl/tdeq_dp.sv =====
// Datapath for the tail-drop egress queue: entry memory, pointers, link
// state, statistics counters, config registers and the result register.
// Depends on tdeq_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps

module tdeq_dp import tdeq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  // Input beat
  input  logic                 op,
  input  logic [SIZE_W-1:0]    packet_size,
  // Configuration write
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // Result beat
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [STS_W-1:0]     status,
  output logic [SIZE_W-1:0]    head_size,
  output logic [TICK_W-1:0]    queue_delay,
  output logic [OCC_W-1:0]     occupancy,
  output logic [STAT_W-1:0]    total_packets,
  output logic [STAT_W-1:0]    total_bytes,
  output logic [STAT_W-1:0]    dropped_packets,
  output logic [STAT_W-1:0]    dropped_bytes,
  output logic [STAT_W-1:0]    served_packets,
  output logic [STAT_W-1:0]    served_bytes,
  output logic [SUM_W-1:0]     delay_total
);

  // Entry memory
  logic [SIZE_W-1:0] entry_size [QUEUE_DEPTH];
  logic [TICK_W-1:0] entry_tick [QUEUE_DEPTH];

  // Captured beat and head read data
  logic              op_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] rd_size;
  logic [TICK_W-1:0] rd_tick;

  // Queue and link state
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  count;
  logic [TICK_W-1:0] now_tick;
  logic              link_busy;
  logic [BPT_W-1:0]  bits_left;
  logic [SUM_W-1:0]  delay_sum;

  // Configuration
  logic [CAP_W-1:0]  capacity;
  logic [BPT_W-1:0]  bits_per_tick;

  // Execute-stage decode
  logic [CNT_W-1:0]  limit;
  logic              has_room;
  logic              do_store;
  logic              do_tick;
  logic              queue_empty;
  logic              start_svc;
  logic [TICK_W-1:0] qdelay;
  logic [BPT_W-1:0]  bits_now;
  logic              depart;
  logic [BPT_W-1:0]  bits_left_next;
  logic [STS_W-1:0]  status_next;
  logic [PTR_W-1:0]  head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr_next;

  assign sts.out_free = !result_valid || !result_stall;

  // Saturate capacity at the buffer depth
  always_comb begin
    if (32'(capacity) > QUEUE_DEPTH) begin
      limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      limit = CNT_W'(capacity);
    end
  end

  assign has_room    = count < limit;
  assign do_store    = cmd.exec && (op_q == OP_ARRIVAL) && has_room;
  assign do_tick     = cmd.exec && (op_q == OP_TICK);
  assign queue_empty = (count == '0);
  assign start_svc   = !queue_empty && !link_busy;
  assign qdelay      = now_tick - rd_tick;
  assign bits_now    = start_svc ? {1'b0, rd_size, 3'b000} : bits_left;
  assign depart      = (bits_now == '0);

  assign head_ptr_next = (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_ptr_next = (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;

  // Drain the link, saturating at zero
  always_comb begin
    if (bits_now > bits_per_tick) begin
      bits_left_next = bits_now - bits_per_tick;
    end else begin
      bits_left_next = '0;
    end
  end

  // Pick the result status
  always_comb begin
    if (op_q == OP_ARRIVAL) begin
      status_next = has_room ? STS_ACCEPTED : STS_DROPPED;
    end else if (queue_empty) begin
      status_next = STS_IDLE;
    end else if (depart) begin
      status_next = STS_DEPARTED;
    end else begin
      status_next = STS_SENDING;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      size_q <= packet_size;
    end
  end

  // Entry memory: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (do_store) begin
      entry_size[tail_ptr] <= size_q;
      entry_tick[tail_ptr] <= now_tick;
    end
    if (cmd.read) begin
      rd_size <= entry_size[head_ptr];
      rd_tick <= entry_tick[head_ptr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RST;
      bits_per_tick <= BPT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_CAPACITY:      capacity      <= cfg_data[CAP_W-1:0];
        CFG_BITS_PER_TICK: bits_per_tick <= cfg_data[BPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Queue, link and statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr        <= '0;
      tail_ptr        <= '0;
      count           <= '0;
      now_tick        <= '0;
      link_busy       <= 1'b0;
      bits_left       <= '0;
      delay_sum       <= '0;
      total_packets   <= '0;
      total_bytes     <= '0;
      dropped_packets <= '0;
      dropped_bytes   <= '0;
      served_packets  <= '0;
      served_bytes    <= '0;
    end else if (cmd.exec) begin
      if (op_q == OP_ARRIVAL) begin
        total_packets <= total_packets + 1'b1;
        total_bytes   <= total_bytes + STAT_W'(size_q);
        if (has_room) begin
          tail_ptr <= tail_ptr_next;
          count    <= count + 1'b1;
        end else begin
          dropped_packets <= dropped_packets + 1'b1;
          dropped_bytes   <= dropped_bytes + STAT_W'(size_q);
        end
      end else begin
        now_tick <= now_tick + 1'b1;
        if (!queue_empty) begin
          if (start_svc) begin
            delay_sum <= delay_sum + SUM_W'(qdelay);
          end
          if (depart) begin
            served_packets <= served_packets + 1'b1;
            served_bytes   <= served_bytes + STAT_W'(rd_size);
            head_ptr       <= head_ptr_next;
            count          <= count - 1'b1;
            link_busy      <= 1'b0;
            bits_left      <= bits_now;
          end else begin
            link_busy <= 1'b1;
            bits_left <= bits_left_next;
          end
        end
      end
    end
  end

  // Result register: per-item fields; counters drive the ports directly
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.exec) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= status_next;
      head_size   <= (do_tick && !queue_empty) ? rd_size : '0;
      queue_delay <= (do_tick && start_svc) ? qdelay : '0;
    end
  end

  assign occupancy   = OCC_W'(count);
  assign delay_total = delay_sum;

  // Occupancy never exceeds the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("occupancy above buffer depth");

  // An empty queue has coincident pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head_ptr == tail_ptr))
    else $error("empty queue with pointers apart");

  // The link is only busy with a packet held in the buffer
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    link_busy |-> (count != '0))
    else $error("link busy with an empty queue");

  // A new result beat appears only from an execute
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.exec))
    else $error("result beat without execute");

endmodule

// ===== rtl/tail_drop_egress_queue_unit.sv =====
// Top level of the tail-drop egress queue: sequencer plus datapath.
// Depends on tdeq_pkg, tdeq_ctrl and tdeq_dp.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    op, packet_size
//   result    result_valid / result_stall status .. delay_total
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each item takes three steps: capture, head-entry memory read, execute;
// the single read port of the entry memory sets the middle step.
// Execute waits while the result register holds an untaken beat; a new item
// is still captured while a finished result waits.
// Reset is synchronous; entry memory is not cleared, no clearing pass.
// cfg_ready is always high.
`timescale 1ns / 1ps

module tail_drop_egress_queue_unit import tdeq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 op,
  input  logic [SIZE_W-1:0]    packet_size,
  // Configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // Result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [STS_W-1:0]     status,
  output logic [SIZE_W-1:0]    head_size,
  output logic [TICK_W-1:0]    queue_delay,
  output logic [OCC_W-1:0]     occupancy,
  output logic [STAT_W-1:0]    total_packets,
  output logic [STAT_W-1:0]    total_bytes,
  output logic [STAT_W-1:0]    dropped_packets,
  output logic [STAT_W-1:0]    dropped_bytes,
  output logic [STAT_W-1:0]    served_packets,
  output logic [STAT_W-1:0]    served_bytes,
  output logic [SUM_W-1:0]     delay_total
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Config writes are taken every cycle
  assign cfg_ready = 1'b1;

  tdeq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tdeq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .op              (op),
    .packet_size     (packet_size),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .head_size       (head_size),
    .queue_delay     (queue_delay),
    .occupancy       (occupancy),
    .total_packets   (total_packets),
    .total_bytes     (total_bytes),
    .dropped_packets (dropped_packets),
    .dropped_bytes   (dropped_bytes),
    .served_packets  (served_packets),
    .served_bytes    (served_bytes),
    .delay_total     (delay_total)
  );

endmodule
